FILE: hdl/rsp_pkg.sv
// Shared types, codes and defaults of the addressed serial slave responder.
package rsp_pkg;

  localparam int BLOCK_LEN_DEF   = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Width of the stored-byte index and of the receive counter.
  localparam int CNT_W = 4;

  localparam logic OP_LINE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] CMD_RECV    = 8'h01;
  localparam logic [7:0] CMD_SEND    = 8'h02;
  localparam logic [7:0] RSP_GOOD    = 8'hCC;
  localparam logic [7:0] RSP_BAD     = 8'hDD;
  localparam logic [7:0] RSP_UNKNOWN = 8'hAD;

  localparam logic [7:0] NODE_ADDRESS_RST = 8'h03;
  localparam logic [7:0] SEND_BYTE_0_RST  = 8'h0F;
  localparam logic [7:0] SEND_BYTE_1_RST  = 8'h0F;
  localparam logic [7:0] SEND_BYTE_2_RST  = 8'h09;

  localparam logic [1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SEND_BYTE_0  = 2'd1;
  localparam logic [1:0] REG_SEND_BYTE_1  = 2'd2;
  localparam logic [1:0] REG_SEND_BYTE_2  = 2'd3;

  typedef struct packed {
    logic [7:0] node_address;
    logic [7:0] send_byte_0;
    logic [7:0] send_byte_1;
    logic [7:0] send_byte_2;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_TX,
    JOB_READ,
    JOB_SEND
  } job_kind_t;

  // One queued job: a single reply byte, a read-back, or a command 2 run
  // whose closing sum is carried in data.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       good;
  } job_t;

endpackage

FILE: hdl/rsp_regs.sv
// Configuration register bank behind the APB-style port.
module rsp_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [3:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output rsp_pkg::cfg_t    cfg
);
  import rsp_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address <= NODE_ADDRESS_RST;
      cfg_r.send_byte_0  <= SEND_BYTE_0_RST;
      cfg_r.send_byte_1  <= SEND_BYTE_1_RST;
      cfg_r.send_byte_2  <= SEND_BYTE_2_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NODE_ADDRESS: cfg_r.node_address <= cfg_pwdata[7:0];
        REG_SEND_BYTE_0:  cfg_r.send_byte_0  <= cfg_pwdata[7:0];
        REG_SEND_BYTE_1:  cfg_r.send_byte_1  <= cfg_pwdata[7:0];
        REG_SEND_BYTE_2:  cfg_r.send_byte_2  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    unique case (reg_idx)
      REG_NODE_ADDRESS: cfg_prdata[7:0] = cfg_r.node_address;
      REG_SEND_BYTE_0:  cfg_prdata[7:0] = cfg_r.send_byte_0;
      REG_SEND_BYTE_1:  cfg_prdata[7:0] = cfg_r.send_byte_1;
      REG_SEND_BYTE_2:  cfg_prdata[7:0] = cfg_r.send_byte_2;
      default:          cfg_prdata      = 32'd0;
    endcase
  end

endmodule

FILE: hdl/rsp_front.sv
// Front end: accepts items, runs the protocol state and queues reply jobs.
module rsp_front #(
  parameter int BLOCK_LEN = rsp_pkg::BLOCK_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsp_pkg::cfg_t             cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      opcode,
  input  logic [7:0]                line_byte,
  input  logic                      ninth_bit,
  input  logic [rsp_pkg::CNT_W-1:0] read_index,
  input  logic                      queue_full,
  output logic                      push,
  output rsp_pkg::job_t             push_job
);
  import rsp_pkg::*;

  localparam int IDX_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [CNT_W:0] BLOCK_LEN_W = (CNT_W + 1)'(BLOCK_LEN);

  typedef enum logic [1:0] {
    PH_ADDR,
    PH_CMD,
    PH_RECV,
    PH_CSUM
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       blk_r [BLOCK_LEN];
  logic             blk_we;
  logic             accept;
  logic             job_valid;
  job_t             job;
  logic [CNT_W:0]   count_inc;
  logic [7:0]       send_sum;

  assign in_tready = ~queue_full;
  assign accept    = in_tvalid & in_tready;
  assign push      = accept & job_valid;
  assign push_job  = job;
  assign count_inc = {1'b0, count_r} + (CNT_W + 1)'(1);
  assign send_sum  = sum_r + cfg.send_byte_0 + cfg.send_byte_1 + cfg.send_byte_2;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    blk_we    = 1'b0;
    job_valid = 1'b0;
    job.kind  = JOB_TX;
    job.data  = 8'd0;
    job.good  = 1'b0;
    if (opcode == OP_READ) begin
      // Read-back leaves the protocol state alone.
      job_valid = 1'b1;
      job.kind  = JOB_READ;
      if ({1'b0, read_index} < BLOCK_LEN_W) begin
        job.data = blk_r[read_index[IDX_W-1:0]];
      end
    end else begin
      unique case (phase_r)
        PH_CMD: begin
          job_valid = 1'b1;
          if (line_byte == CMD_SEND) begin
            job.kind  = JOB_SEND;
            job.data  = send_sum;
            sum_nxt   = send_sum;
            phase_nxt = PH_ADDR;
          end else if (line_byte == CMD_RECV) begin
            job.data  = CMD_RECV;
            count_nxt = '0;
            phase_nxt = PH_RECV;
          end else begin
            job.data  = RSP_UNKNOWN;
            phase_nxt = PH_ADDR;
          end
        end
        PH_RECV: begin
          blk_we  = 1'b1;
          sum_nxt = sum_r + line_byte;
          if (count_inc >= BLOCK_LEN_W) begin
            count_nxt = '0;
            phase_nxt = PH_CSUM;
          end else begin
            count_nxt = count_inc[CNT_W-1:0];
          end
        end
        PH_CSUM: begin
          job_valid = 1'b1;
          job.good  = (line_byte == sum_r);
          job.data  = (line_byte == sum_r) ? RSP_GOOD : RSP_BAD;
          phase_nxt = PH_ADDR;
        end
        default: begin
          if (ninth_bit && (line_byte == cfg.node_address)) begin
            job_valid = 1'b1;
            job.data  = line_byte;
            sum_nxt   = 8'd0;
            phase_nxt = PH_CMD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      sum_r   <= 8'd0;
      count_r <= '0;
      for (int i = 0; i < BLOCK_LEN; i++) begin
        blk_r[i] <= 8'd0;
      end
    end else if (accept) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      if (blk_we) begin
        blk_r[count_r[IDX_W-1:0]] <= line_byte;
      end
    end
  end

endmodule

FILE: hdl/rsp_fifo.sv
// Short job queue between the front end and the reply sequencer.
module rsp_fifo #(
  parameter int DEPTH = rsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsp_pkg::job_t push_job,
  input  logic          pop,
  output rsp_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import rsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] DEPTH_W = CNT_W_Q'(DEPTH);

  job_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0] fill_r;

  assign full    = (fill_r == DEPTH_W);
  assign empty   = (fill_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_W_Q'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_W_Q'(1);
      end
    end
  end

endmodule

FILE: hdl/rsp_back.sv
// Reply sequencer: turns queued jobs into result items through an output register.
module rsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rsp_pkg::cfg_t cfg,
  input  logic          queue_empty,
  input  rsp_pkg::job_t queue_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic          out_kind,
  output logic [7:0]    out_tx_byte,
  output logic          out_last,
  output logic          out_good,
  output logic [7:0]    out_read_data
);
  import rsp_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_B0,
    SEQ_B1,
    SEQ_B2,
    SEQ_SUM
  } seq_t;

  seq_t       seq_r, seq_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       valid_r, valid_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic       last_r, last_nxt;
  logic       good_r, good_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       out_free;

  assign out_free      = ~valid_r | out_tready;
  assign out_tvalid    = valid_r;
  assign out_kind      = kind_r;
  assign out_tx_byte   = tx_r;
  assign out_last      = last_r;
  assign out_good      = good_r;
  assign out_read_data = rd_r;

  always_comb begin
    seq_nxt   = seq_r;
    sum_nxt   = sum_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    tx_nxt    = tx_r;
    last_nxt  = last_r;
    good_nxt  = good_r;
    rd_nxt    = rd_r;
    pop       = 1'b0;
    if (out_free) begin
      kind_nxt  = KIND_TX;
      tx_nxt    = 8'd0;
      last_nxt  = 1'b0;
      good_nxt  = 1'b0;
      rd_nxt    = 8'd0;
      valid_nxt = 1'b1;
      unique case (seq_r)
        SEQ_B0: begin
          tx_nxt  = cfg.send_byte_0;
          seq_nxt = SEQ_B1;
        end
        SEQ_B1: begin
          tx_nxt  = cfg.send_byte_1;
          seq_nxt = SEQ_B2;
        end
        SEQ_B2: begin
          tx_nxt  = cfg.send_byte_2;
          seq_nxt = SEQ_SUM;
        end
        SEQ_SUM: begin
          tx_nxt   = sum_r;
          last_nxt = 1'b1;
          seq_nxt  = SEQ_IDLE;
        end
        default: begin
          if (queue_empty) begin
            valid_nxt = 1'b0;
          end else begin
            pop = 1'b1;
            unique case (queue_job.kind)
              JOB_READ: begin
                kind_nxt = KIND_READ;
                rd_nxt   = queue_job.data;
                last_nxt = 1'b1;
              end
              JOB_SEND: begin
                // Echo the command now, the data bytes and sum follow.
                tx_nxt  = CMD_SEND;
                sum_nxt = queue_job.data;
                seq_nxt = SEQ_B0;
              end
              default: begin
                tx_nxt   = queue_job.data;
                good_nxt = queue_job.good;
                last_nxt = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= SEQ_IDLE;
      valid_r <= 1'b0;
    end else begin
      seq_r   <= seq_nxt;
      valid_r <= valid_nxt;
    end
    sum_r  <= sum_nxt;
    kind_r <= kind_nxt;
    tx_r   <= tx_nxt;
    last_r <= last_nxt;
    good_r <= good_nxt;
    rd_r   <= rd_nxt;
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (seq_r == SEQ_IDLE) && !queue_empty)
    else $error("job taken from the queue while a run is still in progress");

  a_run_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != SEQ_IDLE) |-> valid_r)
    else $error("command run in progress without a result on the output");

  a_read_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == KIND_READ)) |-> last_r && !good_r && (tx_r == 8'd0))
    else $error("read reply not a single result");

  a_good_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && good_r) |-> (tx_r == RSP_GOOD) && last_r)
    else $error("frame_good set on a result other than the match reply");

endmodule

FILE: hdl/rs485_addressed_slave_responder_core.sv
// Top level of the addressed serial slave responder.
//
// The in_ stream carries one item per received byte or read-back request;
// the out_ stream carries the reply bytes and read-back results, with
// tlast on the final result caused by each item. The cfg_ port is an
// APB-style register bank (node address and the three command 2 bytes).
// An item is accepted whenever the job queue has room, so the input takes
// one item per clock while in_tready is high. When the queue and the output
// register are empty, the item's job is written into the job queue and then
// into the output register, from which its first result is presented on out_.
// Command 2 produces a run of five results; while the receiver does not
// stall, the sustained output rate is one result per clock, set by the single
// output register.
// If the receiver stalls, the output register holds its result and the
// job queue (QUEUE_DEPTH entries) keeps absorbing items; in_tready falls
// only when the queue is full. Reset returns the protocol to the address
// phase, clears the running sum, the counter and the stored block, empties
// the queue and loads the register defaults; no clearing pass is needed.
module rs485_addressed_slave_responder_core #(
  parameter int BLOCK_LEN   = rsp_pkg::BLOCK_LEN_DEF,
  parameter int QUEUE_DEPTH = rsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] line_byte, [11:8] read_index, [15:12] zero
  input  logic [1:0]  in_tuser,   // [0] opcode, [1] ninth_bit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] tx_byte, [15:8] read_data
  output logic [1:0]  out_tuser,  // [0] kind, [1] frame_good
  output logic        out_tlast,  // last_in_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rsp_pkg::*;

  cfg_t       cfg;
  logic       queue_full;
  logic       queue_empty;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       pop_job;
  logic       out_kind;
  logic       out_good;
  logic [7:0] out_tx_byte;
  logic [7:0] out_read_data;

  assign out_tdata = {out_read_data, out_tx_byte};
  assign out_tuser = {out_good, out_kind};

  rsp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rsp_front #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .opcode     (in_tuser[0]),
    .line_byte  (in_tdata[7:0]),
    .ninth_bit  (in_tuser[1]),
    .read_index (in_tdata[11:8]),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  rsp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  rsp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .queue_empty   (queue_empty),
    .queue_job     (pop_job),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_kind      (out_kind),
    .out_tx_byte   (out_tx_byte),
    .out_last      (out_tlast),
    .out_good      (out_good),
    .out_read_data (out_read_data)
  );

endmodule
